### rtl/core/btpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package btpc_pkg;

  localparam int unsigned DivBits = 32;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_TEMP_COEF_1    = 3'd0;
  localparam logic [2:0] REG_TEMP_COEF_2    = 3'd1;
  localparam logic [2:0] REG_TEMP_COEF_3    = 3'd2;
  localparam logic [2:0] REG_PRESS_COEF_1   = 3'd3;
  localparam logic [2:0] REG_PRESS_COEF_2_3 = 3'd4;
  localparam logic [2:0] REG_PRESS_COEF_4_5 = 3'd5;
  localparam logic [2:0] REG_PRESS_COEF_6_7 = 3'd6;
  localparam logic [2:0] REG_PRESS_COEF_8_9 = 3'd7;

  localparam logic [31:0] PressOffset = 32'd64000;
  localparam logic [31:0] PressBase   = 32'd1048576;
  localparam logic [31:0] PressScale  = 32'd3125;
  localparam logic [31:0] P1Offset    = 32'd32768;
  localparam logic [31:0] TempRound   = 32'd128;

  // Calibration coefficients, already extended to 32 bits (t1 and p1 zero extended, the rest sign extended).
  typedef struct packed {
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] t3;
    logic [31:0] p1;
    logic [31:0] p2;
    logic [31:0] p3;
    logic [31:0] p4;
    logic [31:0] p5;
    logic [31:0] p6;
    logic [31:0] p7;
    logic [31:0] p8;
    logic [31:0] p9;
  } coef_t;

  // Result of the temperature front end.
  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] v1;
    logic [31:0] q0;
    logic [19:0] rp;
  } tfront_t;

  // Fields that ride alongside the divider.
  typedef struct packed {
    logic [31:0] temp;
    logic        dz;
    logic        post;
  } side_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned s);
    return $unsigned($signed(x) >>> s);
  endfunction

endpackage

`default_nettype wire

### rtl/core/btpc_temp.sv
`timescale 1ns / 1ps
`default_nettype none

module btpc_temp (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire logic [19:0]      rt,
  input  wire logic [19:0]      rp,
  input  wire btpc_pkg::coef_t  coef,
  output logic                  out_valid,
  output btpc_pkg::tfront_t     out
);
  import btpc_pkg::*;

  logic [3:0]  vld;
  logic [31:0] s1_ta, s1_tb, s2_a, s2_bb, s3_a, s3_b, s4_fine;
  logic [19:0] s1_rp, s2_rp, s3_rp, s4_rp;
  logic [31:0] fine5;

  // Valid bits move with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[2:0], in_valid};
      out_valid <= vld[3];
    end
  end

  assign fine5 = (s4_fine << 2) + s4_fine;

  // Five stages: differences, products, scaling, fine value, outputs.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_ta   <= {15'd0, rt[19:3]} - (coef.t1 << 1);
      s1_tb   <= {16'd0, rt[19:4]} - coef.t1;
      s1_rp   <= rp;
      s2_a    <= s1_ta * coef.t2;
      s2_bb   <= s1_tb * s1_tb;
      s2_rp   <= s1_rp;
      s3_a    <= asr32(s2_a, 11);
      s3_b    <= asr32(s2_bb, 12) * coef.t3;
      s3_rp   <= s2_rp;
      s4_fine <= s3_a + asr32(s3_b, 14);
      s4_rp   <= s3_rp;
      out.temp <= asr32(fine5 + TempRound, 8);
      out.v1   <= asr32(s4_fine, 1) - PressOffset;
      out.q0   <= asr32(asr32(s4_fine, 1) - PressOffset, 2);
      out.rp   <= s4_rp;
    end
  end

endmodule

`default_nettype wire

### rtl/core/btpc_press_pre.sv
`timescale 1ns / 1ps
`default_nettype none

module btpc_press_pre (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire btpc_pkg::tfront_t in,
  input  wire btpc_pkg::coef_t   coef,
  output logic                   out_valid,
  output logic [31:0]            num,
  output logic [31:0]            den,
  output btpc_pkg::side_t        side
);
  import btpc_pkg::*;

  logic [4:0]  vld;
  logic [31:0] t6, t7, t8, t9, t10;
  logic [19:0] r6, r7, r8;
  logic [31:0] s6_q, s6_m5, s6_m2, s6_v1;
  logic [31:0] s7_v2a, s7_m3, s7_m5, s7_m2;
  logic [31:0] s8_v2, s8_v1;
  logic [31:0] s9_w, s9_pn;
  logic [31:0] s10_d, s10_pm;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[3:0], in_valid};
      out_valid <= vld[4];
    end
  end

  // Pressure terms, one multiplier deep per stage.
  always_ff @(posedge clk) begin
    if (en) begin
      s6_q   <= in.q0 * in.q0;
      s6_m5  <= in.v1 * coef.p5;
      s6_m2  <= coef.p2 * in.v1;
      s6_v1  <= in.v1;
      t6     <= in.temp;
      r6     <= in.rp;
      s7_v2a <= asr32(s6_q, 11) * coef.p6;
      s7_m3  <= coef.p3 * asr32(s6_q, 13);
      s7_m5  <= s6_m5;
      s7_m2  <= s6_m2;
      t7     <= t6;
      r7     <= r6;
      s8_v2  <= asr32(s7_v2a + (s7_m5 << 1), 2) + (coef.p4 << 16);
      s8_v1  <= asr32(asr32(s7_m3, 3) + asr32(s7_m2, 1), 18);
      t8     <= t7;
      r8     <= r7;
      s9_w   <= (P1Offset + s8_v1) * coef.p1;
      s9_pn  <= (PressBase - {12'd0, r8}) - asr32(s8_v2, 12);
      t9     <= t8;
      s10_d  <= asr32(s9_w, 15);
      s10_pm <= s9_pn * PressScale;
      t10    <= t9;
      // Large values are divided first and doubled after.
      num       <= s10_pm[31] ? s10_pm : (s10_pm << 1);
      den       <= s10_d;
      side.temp <= t10;
      side.dz   <= (s10_d == '0);
      side.post <= s10_pm[31];
    end
  end

  // The raw v1 copy is not needed past the first stage.
  logic unused_v1;
  assign unused_v1 = ^s6_v1;

endmodule

`default_nettype wire

### rtl/core/btpc_div.sv
`timescale 1ns / 1ps
`default_nettype none

module btpc_div (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire logic [31:0]     num,
  input  wire logic [31:0]     den,
  input  wire btpc_pkg::side_t in_side,
  output logic                 out_valid,
  output logic [31:0]          quo,
  output btpc_pkg::side_t      out_side
);
  import btpc_pkg::*;

  logic [DivBits:0]  vld;
  logic [31:0]       rem_s [DivBits+1];
  logic [31:0]       num_s [DivBits+1];
  logic [31:0]       quo_s [DivBits+1];
  logic [31:0]       den_s [DivBits+1];
  side_t             side_s [DivBits+1];

  assign vld[0]    = in_valid;
  assign rem_s[0]  = '0;
  assign num_s[0]  = num;
  assign quo_s[0]  = '0;
  assign den_s[0]  = den;
  assign side_s[0] = in_side;

  // Restoring divider, one quotient bit per stage.
  for (genvar i = 0; i < DivBits; i++) begin : g_stage
    logic [32:0] trial;
    logic        fits;
    assign trial = {rem_s[i], num_s[i][31]};
    assign fits  = (trial >= {1'b0, den_s[i]});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[i+1]  <= fits ? 32'(trial - {1'b0, den_s[i]}) : trial[31:0];
        num_s[i+1]  <= num_s[i] << 1;
        quo_s[i+1]  <= {quo_s[i][30:0], fits};
        den_s[i+1]  <= den_s[i];
        side_s[i+1] <= side_s[i];
      end
    end
  end

  assign out_valid = vld[DivBits];
  assign quo       = quo_s[DivBits];
  assign out_side  = side_s[DivBits];

  logic unused_tail;
  assign unused_tail = ^{rem_s[DivBits], num_s[DivBits], den_s[DivBits]};

endmodule

`default_nettype wire

### rtl/core/btpc_press_post.sv
`timescale 1ns / 1ps
`default_nettype none

module btpc_press_post (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire logic [31:0]     quo,
  input  wire btpc_pkg::side_t in_side,
  input  wire btpc_pkg::coef_t coef,
  output logic                 out_valid,
  output logic [31:0]          temp,
  output logic [31:0]          press,
  output logic                 dz
);
  import btpc_pkg::*;

  logic [2:0]  vld;
  logic [31:0] p1, p2, p3;
  logic [31:0] sq2, m8_2, m8_3, x3;
  logic [31:0] pp;
  side_t       d1, d2, d3;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[1:0], in_valid};
      out_valid <= vld[2];
    end
  end

  assign pp = p1 >> 3;

  // Undo the pre-shift, then apply the second-order correction.
  always_ff @(posedge clk) begin
    if (en) begin
      p1    <= in_side.post ? (quo << 1) : quo;
      d1    <= in_side;
      sq2   <= pp * pp;
      m8_2  <= (p1 >> 2) * coef.p8;
      p2    <= p1;
      d2    <= d1;
      x3    <= coef.p9 * (sq2 >> 13);
      m8_3  <= m8_2;
      p3    <= p2;
      d3    <= d2;
      temp  <= d3.temp;
      dz    <= d3.dz;
      press <= d3.dz ? '0
             : p3 + asr32(asr32(x3, 12) + asr32(m8_3, 13) + coef.p7, 4);
    end
  end

  logic unused_post;
  assign unused_post = d3.post;

endmodule

`default_nettype wire

### rtl/core/baro_temp_press_compensation_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Integer barometric compensation pipeline. Each request on the slave stream
// carries one raw temperature and one raw pressure reading; each result
// request gives the temperature in 0.01 degC, the pressure in Pa and a flag
// in tuser that is set when the pressure divisor was zero (pressure then 0).
// One reading is accepted every clock cycle while no result is held at the
// output. From acceptance to output a reading passes the temperature stages,
// the pressure-term stages, the bit-per-stage divider and the final correction
// and output register. The whole pipeline stalls together while the output is
// held. Calibration registers are written through cfg_we/cfg_addr/cfg_wdata and
// must only change while the pipeline is empty.
module baro_temp_press_compensation_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // raw_temperature[19:0], raw_pressure[39:20]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,   // temperature_centi[31:0], pressure_pa[63:32]
  output logic             m_axis_tuser,   // divisor_zero
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [31:0] cfg_wdata
);
  import btpc_pkg::*;

  logic [15:0] temp_coef_1, temp_coef_2, temp_coef_3, press_coef_1;
  logic [31:0] press_coef_2_3, press_coef_4_5, press_coef_6_7, press_coef_8_9;
  coef_t       coef;
  logic        en;
  logic        tf_valid, pre_valid, div_valid;
  tfront_t     tf;
  logic [31:0] num, den, quo, temp, press;
  side_t       pre_side, div_side;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coef_1    <= '0;
      temp_coef_2    <= '0;
      temp_coef_3    <= '0;
      press_coef_1   <= '0;
      press_coef_2_3 <= '0;
      press_coef_4_5 <= '0;
      press_coef_6_7 <= '0;
      press_coef_8_9 <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_TEMP_COEF_1:    temp_coef_1    <= cfg_wdata[15:0];
        REG_TEMP_COEF_2:    temp_coef_2    <= cfg_wdata[15:0];
        REG_TEMP_COEF_3:    temp_coef_3    <= cfg_wdata[15:0];
        REG_PRESS_COEF_1:   press_coef_1   <= cfg_wdata[15:0];
        REG_PRESS_COEF_2_3: press_coef_2_3 <= cfg_wdata;
        REG_PRESS_COEF_4_5: press_coef_4_5 <= cfg_wdata;
        REG_PRESS_COEF_6_7: press_coef_6_7 <= cfg_wdata;
        REG_PRESS_COEF_8_9: press_coef_8_9 <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    coef.t1 = {16'd0, temp_coef_1};
    coef.t2 = sx16(temp_coef_2);
    coef.t3 = sx16(temp_coef_3);
    coef.p1 = {16'd0, press_coef_1};
    coef.p2 = sx16(press_coef_2_3[15:0]);
    coef.p3 = sx16(press_coef_2_3[31:16]);
    coef.p4 = sx16(press_coef_4_5[15:0]);
    coef.p5 = sx16(press_coef_4_5[31:16]);
    coef.p6 = sx16(press_coef_6_7[15:0]);
    coef.p7 = sx16(press_coef_6_7[31:16]);
    coef.p8 = sx16(press_coef_8_9[15:0]);
    coef.p9 = sx16(press_coef_8_9[31:16]);
  end

  // The pipeline advances unless a finished result is being held.
  assign en            = !(m_axis_tvalid && !m_axis_tready);
  assign s_axis_tready = en;

  btpc_temp u_temp (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_axis_tvalid),
    .rt        (s_axis_tdata[19:0]),
    .rp        (s_axis_tdata[39:20]),
    .coef      (coef),
    .out_valid (tf_valid),
    .out       (tf)
  );

  btpc_press_pre u_pre (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (tf_valid),
    .in        (tf),
    .coef      (coef),
    .out_valid (pre_valid),
    .num       (num),
    .den       (den),
    .side      (pre_side)
  );

  btpc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pre_valid),
    .num       (num),
    .den       (den),
    .in_side   (pre_side),
    .out_valid (div_valid),
    .quo       (quo),
    .out_side  (div_side)
  );

  btpc_press_post u_post (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (div_valid),
    .quo       (quo),
    .in_side   (div_side),
    .coef      (coef),
    .out_valid (m_axis_tvalid),
    .temp      (temp),
    .press     (press),
    .dz        (m_axis_tuser)
  );

  assign m_axis_tdata = {press, temp};

`ifndef SYNTHESIS
  // A zero divisor always yields zero pressure.
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[63:32] == '0)
    else $error("divisor_zero set with nonzero pressure");

  // Reset empties the pipeline.
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // A held result must back-pressure the input.
  a_stall_bp: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while output stalled");

  // A held result keeps its value into the next cycle.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && m_axis_tvalid)
    else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

### tb/baro_temp_press_compensation_core_tb.sv
`timescale 1ns / 1ps

module baro_temp_press_compensation_core_tb;
  import btpc_pkg::*;

  localparam int PipeLatency = 47;
  localparam int IdleLimit   = 5000;

  typedef struct packed {
    logic [31:0] pressure_pa;
    logic [31:0] temperature_centi;
    logic        divisor_zero;
  } reading_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = REG_TEMP_COEF_1;
  logic [31:0] cfg_wdata = '0;

  // Shadow copy of the calibration registers.
  logic [31:0] cal_regs [8];

  reading_t pending_readings[$];
  int       error_count = 0;
  int       idle_cycles = 0;
  int       stall_mode = 0;

  baro_temp_press_compensation_core dut (.*);

  always #5 clk = ~clk;

  function automatic logic [31:0] shr_s(input logic [31:0] x, input int s);
    return $unsigned($signed(x) >>> s);
  endfunction

  function automatic logic [31:0] ext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // Compensation arithmetic, wrapping at 32 bits like the integer scheme.
  function automatic reading_t compensate(input logic [19:0] rt_in, input logic [19:0] rp_in);
    reading_t r;
    logic [31:0] rt, rp, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] a, b, fine, v1, v2, q, p;
    rt = {12'd0, rt_in};
    rp = {12'd0, rp_in};
    t1 = {16'd0, cal_regs[REG_TEMP_COEF_1][15:0]};
    t2 = ext16(cal_regs[REG_TEMP_COEF_2][15:0]);
    t3 = ext16(cal_regs[REG_TEMP_COEF_3][15:0]);
    p1 = {16'd0, cal_regs[REG_PRESS_COEF_1][15:0]};
    p2 = ext16(cal_regs[REG_PRESS_COEF_2_3][15:0]);
    p3 = ext16(cal_regs[REG_PRESS_COEF_2_3][31:16]);
    p4 = ext16(cal_regs[REG_PRESS_COEF_4_5][15:0]);
    p5 = ext16(cal_regs[REG_PRESS_COEF_4_5][31:16]);
    p6 = ext16(cal_regs[REG_PRESS_COEF_6_7][15:0]);
    p7 = ext16(cal_regs[REG_PRESS_COEF_6_7][31:16]);
    p8 = ext16(cal_regs[REG_PRESS_COEF_8_9][15:0]);
    p9 = ext16(cal_regs[REG_PRESS_COEF_8_9][31:16]);
    a = shr_s(((rt >> 3) - (t1 << 1)) * t2, 11);
    b = (rt >> 4) - t1;
    b = shr_s(shr_s(b * b, 12) * t3, 14);
    fine = a + b;
    r.temperature_centi = shr_s(fine * 32'd5 + 32'd128, 8);
    v1 = shr_s(fine, 1) - 32'd64000;
    q = shr_s(v1, 2);
    q = q * q;
    v2 = shr_s(q, 11) * p6;
    v2 = v2 + ((v1 * p5) << 1);
    v2 = shr_s(v2, 2) + (p4 << 16);
    v1 = shr_s(shr_s(p3 * shr_s(q, 13), 3) + shr_s(p2 * v1, 1), 18);
    v1 = shr_s((32'd32768 + v1) * p1, 15);
    if (v1 == 0) begin
      r.divisor_zero = 1'b1;
      p = '0;
    end else begin
      r.divisor_zero = 1'b0;
      p = ((32'd1048576 - rp) - shr_s(v2, 12)) * 32'd3125;
      if (p < 32'h8000_0000) p = (p << 1) / v1;
      else p = (p / v1) << 1;
      v1 = shr_s(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
      v2 = shr_s((p >> 2) * p8, 13);
      p = p + shr_s(v1 + v2 + p7, 4);
    end
    r.pressure_pa = p;
    return r;
  endfunction

  // Receiver stall pattern: free running, periodic, or random.
  always @(negedge clk) begin
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($time / 10) % 7 < 4;
      default: m_axis_tready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Result checker and idle watchdog.
  always @(posedge clk) begin
    reading_t got, want;
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.temperature_centi = m_axis_tdata[31:0];
        got.pressure_pa = m_axis_tdata[63:32];
        got.divisor_zero = m_axis_tuser;
        if (pending_readings.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          error_count++;
        end else begin
          want = pending_readings.pop_front();
          if (got.temperature_centi !== want.temperature_centi) begin
            $display("%0t: temperature expected %h actual %h", $time,
                     want.temperature_centi, got.temperature_centi);
            error_count++;
          end
          if (got.pressure_pa !== want.pressure_pa) begin
            $display("%0t: pressure expected %h actual %h", $time,
                     want.pressure_pa, got.pressure_pa);
            error_count++;
          end
          if (got.divisor_zero !== want.divisor_zero) begin
            $display("%0t: divisor flag expected %b actual %b", $time,
                     want.divisor_zero, got.divisor_zero);
            error_count++;
          end
        end
      end
    end
  end

  // Sends one reading request; valid stays high when another follows at once.
  task automatic send_reading(input logic [19:0] rt, input logic [19:0] rp,
                              input bit keep_valid);
    s_axis_tdata <= {rp, rt};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    pending_readings.push_back(compensate(rt, rp));
    @(negedge clk);
    if (!keep_valid) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    while (pending_readings.size() != 0) @(negedge clk);
    repeat (PipeLatency + 5) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx <= REG_PRESS_COEF_1) cal_regs[idx] = {16'd0, value[15:0]};
    else cal_regs[idx] = value;
    @(negedge clk);
  endtask

  // Typical calibration values of a real sensor.
  task automatic load_typical_cal();
    write_reg(REG_TEMP_COEF_1, 32'd27504);
    write_reg(REG_TEMP_COEF_2, 32'd26435);
    write_reg(REG_TEMP_COEF_3, 32'hFFFF_FC18);
    write_reg(REG_PRESS_COEF_1, 32'd36477);
    write_reg(REG_PRESS_COEF_2_3, {16'd3024, 16'hD4BC});
    write_reg(REG_PRESS_COEF_4_5, {16'h008C, 16'h1AE5});
    write_reg(REG_PRESS_COEF_6_7, {16'd15500, 16'hFFF9});
    write_reg(REG_PRESS_COEF_8_9, {16'd6000, 16'hC6F0});
  endtask

  // Random items in bursts of random length, with or without a random gap after each burst.
  task automatic send_bursts(input int count, input bit realistic);
    int burst, left;
    logic [19:0] rt, rp;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 30);
      if (burst > left) burst = left;
      for (int i = 0; i < burst; i++) begin
        if (realistic && $urandom_range(0, 9) != 0) begin
          rt = 20'($urandom_range(380000, 620000));
          rp = 20'($urandom_range(200000, 480000));
        end else begin
          rt = 20'($urandom);
          rp = 20'($urandom);
        end
        send_reading(rt, rp, i != burst - 1);
      end
      left -= burst;
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  // Zero calibration after reset: the divisor is zero for every reading.
  task automatic test_reset_cal();
    stall_mode = 0;
    send_reading(20'd0, 20'd0, 1'b1);
    send_reading(20'hFFFFF, 20'hFFFFF, 1'b1);
    send_reading(20'h55555, 20'hAAAAA, 1'b0);
    wait_drained();
  endtask

  // Field extremes with typical calibration.
  task automatic test_directed_extremes();
    load_typical_cal();
    stall_mode = 1;
    send_reading(20'd519888, 20'd415148, 1'b0);
    send_reading(20'd0, 20'd0, 1'b1);
    send_reading(20'hFFFFF, 20'hFFFFF, 1'b1);
    send_reading(20'd0, 20'hFFFFF, 1'b1);
    send_reading(20'hFFFFF, 20'd0, 1'b1);
    send_reading(20'h55555, 20'hAAAAA, 1'b1);
    send_reading(20'hAAAAA, 20'h55555, 1'b0);
    wait_drained();
  endtask

  // Coefficients at their extremes, including a divisor forced to zero.
  task automatic test_coef_extremes();
    write_reg(REG_TEMP_COEF_1, 32'hFFFF_FFFF);
    write_reg(REG_TEMP_COEF_2, 32'h0000_8000);
    write_reg(REG_TEMP_COEF_3, 32'h0000_7FFF);
    write_reg(REG_PRESS_COEF_1, 32'h0000_FFFF);
    write_reg(REG_PRESS_COEF_2_3, 32'h8000_7FFF);
    write_reg(REG_PRESS_COEF_4_5, 32'h7FFF_8000);
    write_reg(REG_PRESS_COEF_6_7, 32'hFFFF_0001);
    write_reg(REG_PRESS_COEF_8_9, 32'h8000_8000);
    stall_mode = 2;
    send_reading(20'd0, 20'd0, 1'b1);
    send_reading(20'hFFFFF, 20'hFFFFF, 1'b1);
    send_reading(20'h12345, 20'h6789A, 1'b0);
    wait_drained();
    write_reg(REG_PRESS_COEF_1, 32'd0);
    send_reading(20'd500000, 20'd400000, 1'b1);
    send_reading(20'hFFFFF, 20'd1, 1'b0);
    wait_drained();
  endtask

  // Realistic readings with all three stall patterns.
  task automatic test_random_typical();
    load_typical_cal();
    for (int m = 0; m < 3; m++) begin
      stall_mode = m;
      send_bursts(250, 1'b1);
    end
    // The sender holds off until the pipeline has fully drained.
    wait_drained();
  endtask

  // Random calibration sets, each followed by random readings.
  task automatic test_random_cal();
    for (int s = 0; s < 8; s++) begin
      for (int r = 0; r <= REG_PRESS_COEF_8_9; r++) write_reg(r[2:0], $urandom);
      if (s == 3) write_reg(REG_PRESS_COEF_1, 32'd0);
      stall_mode = s % 3;
      send_bursts(50, 1'b0);
      wait_drained();
    end
  endtask

  initial begin
    for (int i = 0; i < 8; i++) cal_regs[i] = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_cal();
    test_directed_extremes();
    test_coef_extremes();
    test_random_typical();
    test_random_cal();
    wait_drained();
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### baro_temp_press_compensation_core.f
rtl/core/btpc_pkg.sv
rtl/core/btpc_temp.sv
rtl/core/btpc_press_pre.sv
rtl/core/btpc_div.sv
rtl/core/btpc_press_post.sv
rtl/core/baro_temp_press_compensation_core.sv
tb/baro_temp_press_compensation_core_tb.sv
